// ===== src/encpc_pkg.sv =====
package encpc_pkg;

    localparam int unsigned TICK_W    = 16;
    localparam int unsigned SPAN_W    = 10;
    localparam int unsigned CPR_W     = 16;
    localparam int unsigned TGT_W     = 9;
    localparam int unsigned DRV_W     = 8;
    localparam int unsigned CFG_W     = 16;
    localparam int unsigned CFG_IDX_W = 3;

    // tick * span, signed
    localparam int unsigned PROD_W    = TICK_W + SPAN_W;
    // magnitude of the product, one quotient bit per divider step
    localparam int unsigned MAG_W     = PROD_W - 1;
    localparam int unsigned DIV_STEPS = MAG_W;
    localparam int unsigned CNT_W     = $clog2(DIV_STEPS);
    // target - angle and its product with the gain
    localparam int unsigned ERR_W     = TICK_W + 2;
    localparam int unsigned EPROD_W   = ERR_W + DRV_W + 1;

    localparam logic [DRV_W-1:0]  GAIN_RST  = DRV_W'(5);
    localparam logic [DRV_W-1:0]  MAX_RST   = DRV_W'(255);
    localparam logic [DRV_W-1:0]  MIN_RST   = DRV_W'(100);
    localparam logic [CPR_W-1:0]  CPR_RST   = CPR_W'(2299);
    localparam logic [SPAN_W-1:0] SPAN_RST  = SPAN_W'(359);

    localparam logic signed [TICK_W-1:0] TICK_MAX = {1'b0, {(TICK_W-1){1'b1}}};
    localparam logic signed [TICK_W-1:0] TICK_MIN = {1'b1, {(TICK_W-1){1'b0}}};

    localparam logic KIND_EDGE   = 1'b0;
    localparam logic KIND_TARGET = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN      = 3'd0,
        CFG_MAX_DRIVE = 3'd1,
        CFG_MIN_DRIVE = 3'd2,
        CFG_CPR       = 3'd3,
        CFG_SPAN      = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic             kind;
        logic             level_a;
        logic             level_b;
        logic [TGT_W-1:0] target_deg;
    } t_in_item;

    typedef struct packed {
        logic [DRV_W-1:0]         drive_cw;
        logic [DRV_W-1:0]         drive_ccw;
        logic signed [TICK_W-1:0] angle_deg;
        logic                     at_target;
    } t_out_item;

    typedef struct packed {
        logic capture;
        logic mul;
        logic div_init;
        logic div_step;
        logic angle_load;
        logic err_load;
        logic out_load;
    } t_cmd;

endpackage

// ===== src/encoder_p_position_controller_core.sv =====
// Proportional position controller for a quadrature encoder. Each input transaction is
// either an encoder A-edge (kind 0) or a new target angle (kind 1), and each gives one
// result transaction with the drive duty for both directions, the angle and an at-target
// flag. For an edge, the angle is ticks * degree_span / counts_per_rev, found by a
// restoring divider that retires one quotient bit per cycle; the product, divider
// set-up, divider steps, angle, error and output steps run in that order. A target update
// skips the product and divider and runs only the error and output steps. One transaction
// is in work at a time; a finished result waits in an output register while the next
// transaction is accepted. Configuration writes apply at once and belong to idle time;
// degree_span and counts_per_rev change the angle only at the next edge.
module encoder_p_position_controller_core import encpc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_data
);

    t_cmd w_cmd;

    encpc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_kind   (i_in_data.kind),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd)
    );

    encpc_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_data  (i_in_data),
        .i_cmd      (w_cmd),
        .o_out_data (o_out_data)
    );

endmodule

// ===== src/encpc_dp.sv =====
module encpc_dp import encpc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  t_in_item             i_in_data,
    input  t_cmd                 i_cmd,
    output t_out_item            o_out_data
);

    logic [DRV_W-1:0]  r_gain, r_max, r_min;
    logic [CPR_W-1:0]  r_cpr;
    logic [SPAN_W-1:0] r_span;

    logic signed [TICK_W-1:0] r_tick;
    logic signed [TICK_W-1:0] r_angle;
    logic [TGT_W-1:0]         r_target;

    logic signed [PROD_W-1:0]  r_prod;
    logic                      r_neg;
    logic [CPR_W-1:0]          r_divisor;
    logic [CPR_W-1:0]          r_rem;
    logic [MAG_W-1:0]          r_quo;
    logic signed [EPROD_W-1:0] r_eprod;
    logic                      r_err_zero;
    t_out_item                 r_out;

    logic signed [TICK_W-1:0]  n_tick;
    logic signed [PROD_W-1:0]  n_prod;
    logic [PROD_W-1:0]         n_mag;
    logic [CPR_W:0]            n_rem_sh;
    logic                      n_ge;
    logic [CPR_W:0]            n_diff;
    logic signed [TICK_W-1:0]  n_angle;
    logic signed [ERR_W-1:0]   n_err;
    logic signed [EPROD_W-1:0] n_eprod;
    logic signed [EPROD_W-1:0] n_lim;
    logic [EPROD_W-1:0]        n_abs;
    logic                      n_dir_ccw;
    logic [DRV_W-1:0]          n_mag_drv;
    logic [DRV_W-1:0]          n_boost;
    t_out_item                 n_out;

    // saturating tick step
    always_comb begin
        n_tick = r_tick;
        if (i_in_data.level_a != i_in_data.level_b) begin
            if (r_tick != TICK_MAX) n_tick = r_tick + TICK_W'(1);
        end else begin
            if (r_tick != TICK_MIN) n_tick = r_tick - TICK_W'(1);
        end
    end

    always_comb begin
        n_prod   = PROD_W'(r_tick) * PROD_W'($signed({1'b0, r_span}));
        n_mag    = r_prod[PROD_W-1] ? PROD_W'(-r_prod) : PROD_W'(r_prod);
        n_rem_sh = {r_rem, r_quo[MAG_W-1]};
        n_ge     = n_rem_sh >= {1'b0, r_divisor};
        n_diff   = n_rem_sh - {1'b0, r_divisor};
    end

    // truncated quotient, saturated to 16 bits
    always_comb begin
        if (|r_quo[MAG_W-1:TICK_W-1]) begin
            n_angle = r_neg ? TICK_MIN : TICK_MAX;
        end else begin
            n_angle = r_neg ? -$signed(r_quo[TICK_W-1:0]) : $signed(r_quo[TICK_W-1:0]);
        end
    end

    always_comb begin
        n_err   = $signed({{(ERR_W-TGT_W){1'b0}}, r_target}) - ERR_W'(r_angle);
        n_eprod = EPROD_W'(n_err) * EPROD_W'($signed({1'b0, r_gain}));
    end

    // clamp to +/- max, then lift to min; a zero clamp counts as clockwise
    always_comb begin
        n_lim     = $signed({{(EPROD_W-DRV_W){1'b0}}, r_max});
        n_abs     = r_eprod[EPROD_W-1] ? EPROD_W'(-r_eprod) : EPROD_W'(r_eprod);
        n_dir_ccw = 1'b0;
        n_mag_drv = r_max;
        if (r_eprod > n_lim) begin
            n_dir_ccw = 1'b0;
            n_mag_drv = r_max;
        end else if (r_eprod < -n_lim) begin
            n_dir_ccw = (r_max != '0);
            n_mag_drv = r_max;
        end else begin
            n_dir_ccw = r_eprod[EPROD_W-1];
            n_mag_drv = n_abs[DRV_W-1:0];
        end
        n_boost = (n_mag_drv < r_min) ? r_min : n_mag_drv;

        n_out.angle_deg = r_angle;
        n_out.at_target = r_err_zero;
        n_out.drive_cw  = '0;
        n_out.drive_ccw = '0;
        if (!r_err_zero) begin
            if (n_dir_ccw) n_out.drive_ccw = n_boost;
            else           n_out.drive_cw  = n_boost;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain   <= GAIN_RST;
            r_max    <= MAX_RST;
            r_min    <= MIN_RST;
            r_cpr    <= CPR_RST;
            r_span   <= SPAN_RST;
            r_tick   <= '0;
            r_angle  <= '0;
            r_target <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_GAIN:      r_gain <= i_cfg_data[DRV_W-1:0];
                    CFG_MAX_DRIVE: r_max  <= i_cfg_data[DRV_W-1:0];
                    CFG_MIN_DRIVE: r_min  <= i_cfg_data[DRV_W-1:0];
                    CFG_CPR:       r_cpr  <= i_cfg_data[CPR_W-1:0];
                    CFG_SPAN:      r_span <= i_cfg_data[SPAN_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.capture) begin
                if (i_in_data.kind == KIND_EDGE) r_tick <= n_tick;
                else                             r_target <= i_in_data.target_deg;
            end
            if (i_cmd.angle_load) r_angle <= n_angle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) r_prod <= n_prod;
        if (i_cmd.div_init) begin
            r_neg     <= r_prod[PROD_W-1];
            r_quo     <= n_mag[MAG_W-1:0];
            r_rem     <= '0;
            r_divisor <= (r_cpr == '0) ? CPR_W'(1) : r_cpr;
        end
        if (i_cmd.div_step) begin
            r_rem <= n_ge ? n_diff[CPR_W-1:0] : n_rem_sh[CPR_W-1:0];
            r_quo <= {r_quo[MAG_W-2:0], n_ge};
        end
        if (i_cmd.err_load) begin
            r_eprod    <= n_eprod;
            r_err_zero <= (n_err == '0);
        end
        if (i_cmd.out_load) r_out <= n_out;
    end

    assign o_out_data = r_out;

endmodule

// ===== src/encpc_ctrl.sv =====
module encpc_ctrl import encpc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_kind,
    output logic o_in_stall,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV_INIT,
        S_DIV,
        S_ANGLE,
        S_ERR,
        S_FIN
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_cnt;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             n_in_accept;
    logic             n_out_free;
    logic             n_last_step;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign n_in_accept = i_in_valid && (r_state == S_IDLE);
    assign n_out_free  = !r_out_valid || !i_out_stall;
    assign n_last_step = (r_cnt == CNT_W'(DIV_STEPS - 1));
    // a held result stays until taken; a new one replaces it in the same cycle
    assign n_out_valid = ((r_state == S_FIN) && n_out_free) || (r_out_valid && i_out_stall);

    always_comb begin
        o_cmd            = '0;
        o_cmd.capture    = n_in_accept;
        o_cmd.mul        = (r_state == S_MUL);
        o_cmd.div_init   = (r_state == S_DIV_INIT);
        o_cmd.div_step   = (r_state == S_DIV);
        o_cmd.angle_load = (r_state == S_ANGLE);
        o_cmd.err_load   = (r_state == S_ERR);
        o_cmd.out_load   = (r_state == S_FIN) && n_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            unique case (r_state)
                S_IDLE: begin
                    if (n_in_accept) r_state <= (i_in_kind == KIND_EDGE) ? S_MUL : S_ERR;
                end
                S_MUL: begin
                    r_state <= S_DIV_INIT;
                end
                S_DIV_INIT: begin
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (n_last_step) r_state <= S_ANGLE;
                end
                S_ANGLE: begin
                    r_state <= S_ERR;
                end
                S_ERR: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (n_out_free) r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt <= CNT_W'(DIV_STEPS - 1)))
        else $error("divider step count out of range");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_in_accept |=> o_in_stall)
        else $error("controller still idle after taking a transaction");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || !i_out_stall))
        else $error("result register overwritten while held");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> o_out_valid)
        else $error("loaded result not presented");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.mul, o_cmd.div_init, o_cmd.div_step, o_cmd.angle_load,
                  o_cmd.err_load, o_cmd.out_load, o_cmd.capture}))
        else $error("more than one datapath command at once");
`endif

endmodule
